@@ hdl/sgr_pkg.sv @@
// sgr_pkg: request, record and result types plus request and status codes
// for the generation-tagged slot registry.
// No dependencies.
package sgr_pkg;

	localparam int CFG_W  = 5;
	localparam int MASK_W = 16;

	typedef logic [2:0] req_kind_t;
	typedef logic [1:0] status_t;

	localparam req_kind_t REQ_ALLOC   = 3'd0;
	localparam req_kind_t REQ_RELEASE = 3'd1;
	localparam req_kind_t REQ_BEAT    = 3'd2;
	localparam req_kind_t REQ_CLEAN   = 3'd3;
	localparam req_kind_t REQ_LIVE    = 3'd4;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_ERROR     = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		req_kind_t          req_type;
		logic [30:0]        owner_pid;
		logic [63:0]        owner_start_time;
		logic [63:0]        owner_boot_hash;
		logic [31:0]        mode_word;
		logic [63:0]        shm_epoch;
		logic [3:0]         handle_idx;
		logic [63:0]        handle_gen;
		logic [63:0]        heartbeat_value;
		logic [MASK_W-1:0]  alive_mask;
	} req_t;

	// one slot record as kept in the record memory
	typedef struct packed {
		logic [63:0] gen_tag;
		logic [31:0] mode;
		logic [30:0] pid;
		logic [63:0] beat;
		logic [63:0] shm_gen;
		logic [63:0] start;
		logic [63:0] boot;
	} rec_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  grant_idx;
		logic [63:0] grant_gen;
		logic [4:0]  count_out;
		logic [4:0]  active_count_out;
		logic [63:0] registry_generation_out;
	} res_t;

endpackage

@@ hdl/sgr_rec_mem.sv @@
// sgr_rec_mem: slot record memory, one write port, one registered read port.
// Uses sgr_pkg::rec_t.
module sgr_rec_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  sgr_pkg::rec_t   wdata,
	input  logic [AW-1:0]   raddr,
	output sgr_pkg::rec_t   rdata
);
	import sgr_pkg::*;

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/sgr_seq.sv @@
// sgr_seq: request sequencer; walks slots one per cycle, owns the active
// flags, global generation and active count. Uses sgr_pkg, drives sgr_rec_mem.
module sgr_seq #(
	parameter int SLOTS = 16,
	parameter int IW    = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sgr_pkg::CFG_W-1:0]  cfg_slots,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  sgr_pkg::req_t              in_req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output sgr_pkg::res_t              res,
	output logic                       mem_we,
	output logic [IW-1:0]              mem_waddr,
	output sgr_pkg::rec_t              mem_wdata,
	output logic [IW-1:0]              mem_raddr,
	input  sgr_pkg::rec_t              mem_rdata
);
	import sgr_pkg::*;

	localparam int CW  = IW + 1;
	localparam int ACW = (SLOTS > 1) ? $clog2(SLOTS + 1) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [SLOTS-1:0] active_q, active_d;
	logic [63:0]      gen_q, gen_d;
	logic [ACW-1:0]   act_cnt_q, act_cnt_d;
	req_t             req_q, req_d;
	logic [CW-1:0]    idx_q, idx_d;
	logic [4:0]       tally_q, tally_d;
	status_t          status_q, status_d;
	logic [3:0]       gidx_q, gidx_d;
	logic [63:0]      ggen_q, ggen_d;

	logic [4:0]       n_used;
	logic [6:0]       idx7;
	logic [IW-1:0]    cur;
	logic [IW-1:0]    sidx;
	logic             walk_end;
	logic             alive;
	logic [63:0]      gen_inc;
	logic [ACW-1:0]   act_dec;
	rec_t             clear_rec;
	rec_t             alloc_rec;
	rec_t             beat_rec;

	// slots_in_use above SLOTS acts as SLOTS
	assign n_used   = (7'(cfg_slots) > 7'(SLOTS)) ? 5'(SLOTS) : cfg_slots;
	assign idx7     = 7'(idx_q);
	assign cur      = idx_q[IW-1:0];
	assign sidx     = IW'(req_q.handle_idx);
	assign walk_end = idx7 >= 7'(n_used);
	// slots past the mask width count as dead
	assign alive    = (idx7 < 7'(MASK_W)) && req_q.alive_mask[idx7[3:0]];
	assign gen_inc  = gen_q + 64'd1;
	assign act_dec  = (act_cnt_q != '0) ? act_cnt_q - ACW'(1) : act_cnt_q;

	always_comb begin
		clear_rec         = '0;
		clear_rec.gen_tag = gen_inc;
		alloc_rec         = '0;
		alloc_rec.gen_tag = gen_inc;
		alloc_rec.mode    = req_q.mode_word;
		alloc_rec.pid     = req_q.owner_pid;
		alloc_rec.beat    = gen_inc;
		alloc_rec.shm_gen = req_q.shm_epoch;
		alloc_rec.start   = req_q.owner_start_time;
		alloc_rec.boot    = req_q.owner_boot_hash;
		beat_rec          = mem_rdata;
		beat_rec.beat     = req_q.heartbeat_value;
	end

	always_comb begin
		state_d   = state_q;
		active_d  = active_q;
		gen_d     = gen_q;
		act_cnt_d = act_cnt_q;
		req_d     = req_q;
		idx_d     = idx_q;
		tally_d   = tally_q;
		status_d  = status_q;
		gidx_d    = gidx_q;
		ggen_d    = ggen_q;
		mem_we    = 1'b0;
		mem_waddr = cur;
		mem_wdata = clear_rec;
		mem_raddr = sidx;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_d    = in_req;
					idx_d    = '0;
					tally_d  = '0;
					gidx_d   = '0;
					ggen_d   = '0;
					status_d = ST_ERROR;
					state_d  = S_DONE;
					if (n_used != '0) begin
						unique case (in_req.req_type)
							REQ_ALLOC: begin
								if (in_req.owner_pid != '0 && in_req.owner_start_time != '0 &&
								    in_req.owner_boot_hash != '0 && in_req.mode_word != '0) begin
									state_d = S_WALK;
								end
							end
							REQ_RELEASE, REQ_BEAT: begin
								if (in_req.handle_gen != '0 &&
								    (in_req.req_type != REQ_BEAT ||
								     in_req.heartbeat_value != '0)) begin
									if ({1'b0, in_req.handle_idx} >= n_used) begin
										status_d = ST_NOT_FOUND;
									end else begin
										state_d = S_RD;
									end
								end
							end
							REQ_CLEAN, REQ_LIVE: state_d = S_WALK;
							default: ;
						endcase
					end
				end
			end
			S_WALK: begin
				if (walk_end) begin
					status_d = (req_q.req_type == REQ_ALLOC) ? ST_FULL : ST_OK;
					state_d  = S_DONE;
				end else begin
					idx_d = idx_q + CW'(1);
					unique case (req_q.req_type)
						REQ_ALLOC: begin
							if (!active_q[cur]) begin
								mem_we        = 1'b1;
								mem_wdata     = alloc_rec;
								active_d[cur] = 1'b1;
								gen_d         = gen_inc;
								act_cnt_d     = act_cnt_q + ACW'(1);
								gidx_d        = 4'(idx_q);
								ggen_d        = gen_inc;
								status_d      = ST_OK;
								state_d       = S_DONE;
							end
						end
						REQ_CLEAN: begin
							if (active_q[cur] && !alive) begin
								mem_we        = 1'b1;
								active_d[cur] = 1'b0;
								gen_d         = gen_inc;
								act_cnt_d     = act_dec;
								tally_d       = tally_q + 5'd1;
							end
						end
						default: begin
							if (active_q[cur] && alive) begin
								tally_d = tally_q + 5'd1;
							end
						end
					endcase
				end
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				status_d  = ST_NOT_FOUND;
				state_d   = S_DONE;
				mem_waddr = sidx;
				if (active_q[sidx] && mem_rdata.gen_tag == req_q.handle_gen) begin
					status_d = ST_OK;
					mem_we   = 1'b1;
					if (req_q.req_type == REQ_RELEASE) begin
						active_d[sidx] = 1'b0;
						gen_d          = gen_inc;
						act_cnt_d      = act_dec;
					end else begin
						mem_wdata = beat_rec;
					end
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			active_q  <= '0;
			gen_q     <= '0;
			act_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			active_q  <= active_d;
			gen_q     <= gen_d;
			act_cnt_q <= act_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		idx_q    <= idx_d;
		tally_q  <= tally_d;
		status_q <= status_d;
		gidx_q   <= gidx_d;
		ggen_q   <= ggen_d;
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status                  = status_q;
		res.grant_idx               = gidx_q;
		res.grant_gen               = ggen_q;
		res.count_out               = tally_q;
		res.active_count_out        = 5'(act_cnt_q);
		res.registry_generation_out = gen_q;
	end

endmodule

@@ hdl/generation_tagged_slot_registry.sv @@
// generation_tagged_slot_registry: top level of the slot registry (sgr_pkg, sgr_seq, sgr_rec_mem).
// Allocate walks slots up to the one granted (all n when full); cleanup and live count
// walk all n slots, n = min(slots_in_use, SLOTS); release and heartbeat read the slot record
// and then check it; error answers skip both; the slot walk visits one slot per cycle.
// Throughput: one request at a time; the next beat is taken once the result is in the output register.
// Reset clears active flags, generation and active count at once; slots_in_use resets to 16.
module generation_tagged_slot_registry #(
	parameter int SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	// configuration: slots_in_use
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    cfg_data,
	// request beat
	input  logic          s_tvalid,
	output logic          s_tready,
	// owner_pid, owner_start_time, owner_boot_hash, mode word, shm epoch,
	// handle index, handle generation, heartbeat_value, alive_mask, zero pad
	input  logic [407:0]  s_tdata,
	// req_type
	input  logic [2:0]    s_tuser,
	// result beat
	output logic          m_tvalid,
	input  logic          m_tready,
	// granted index, granted generation, count_out, active_count_out,
	// registry_generation_out, zero pad
	output logic [143:0]  m_tdata,
	// status
	output logic [1:0]    m_tuser
);
	import sgr_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [CFG_W-1:0] slots_q;
	req_t             req;
	res_t             res;
	res_t             out_q;
	logic             out_valid_q;
	logic             res_valid;
	logic             res_ready;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [IW-1:0]    mem_raddr;
	rec_t             mem_wdata;
	rec_t             mem_rdata;

	// config register; the user must write it only while idle, the block does not enforce it, so no guard here
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= 5'd16;
		end else if (cfg_valid) begin
			slots_q <= cfg_data;
		end
	end

	// unpack request beat
	always_comb begin
		req.req_type         = s_tuser;
		req.owner_pid        = s_tdata[30:0];
		req.owner_start_time = s_tdata[94:31];
		req.owner_boot_hash  = s_tdata[158:95];
		req.mode_word        = s_tdata[190:159];
		req.shm_epoch        = s_tdata[254:191];
		req.handle_idx       = s_tdata[258:255];
		req.handle_gen       = s_tdata[322:259];
		req.heartbeat_value  = s_tdata[386:323];
		req.alive_mask       = s_tdata[402:387];
	end

	sgr_seq #(
		.SLOTS(SLOTS),
		.IW   (IW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_slots(slots_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_req   (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	sgr_rec_mem #(
		.DEPTH(SLOTS),
		.AW   (IW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register: result beat holds until taken
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00,
	                   out_q.registry_generation_out,
	                   out_q.active_count_out,
	                   out_q.count_out,
	                   out_q.grant_gen,
	                   out_q.grant_idx};

endmodule

@@ hdl/sgr_chk.sv @@
// sgr_chk: port-level checks on the slot registry, bound to the top level.
// Uses sgr_pkg status codes.
module sgr_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [143:0]  m_tdata,
	input logic [1:0]    m_tuser
);
	import sgr_pkg::*;

	// result beat holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one request in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// failed requests grant no handle and report no count
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[72:4] == '0)
		else $error("failed request carries handle or count");

	// a granted handle is the registry generation after the grant
	a_grant_gen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67:4] != '0 |-> m_tdata[67:4] == m_tdata[141:78])
		else $error("granted handle differs from registry generation");

endmodule

bind generation_tagged_slot_registry sgr_chk u_sgr_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

@@ dv/generation_tagged_slot_registry_tb.sv @@
// Self-checking testbench for generation_tagged_slot_registry: directed and random
// requests, each result checked field by field against an in-bench slot table.
// Depends on sgr_pkg (codes, request and result structs) and the registry RTL.
module generation_tagged_slot_registry_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sgr_pkg::*;

	localparam int SLOTS     = 16;
	localparam int QUIET_MAX = 2000;	// cycles with no beat on any channel before giving up

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [4:0]    cfg_data  = '0;
	logic          s_tvalid  = 1'b0;
	logic          s_tready;
	// owner_pid, owner_start_time, owner_boot_hash, mode word, shm epoch,
	// handle index, handle generation, heartbeat_value, alive_mask, zero pad
	logic [407:0]  s_tdata   = '0;
	// req_type
	logic [2:0]    s_tuser   = '0;
	logic          m_tvalid;
	logic          m_tready  = 1'b0;
	// granted index, granted generation, count_out, active_count_out,
	// registry_generation_out, zero pad
	logic [143:0]  m_tdata;
	// status
	logic [1:0]    m_tuser;

	generation_tagged_slot_registry #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the registry. Only what can reach a result is kept: owner identity,
	// mode, shm generation and heartbeat stamp never show on the result beat.
	logic        slot_busy [SLOTS];
	logic [63:0] slot_tag  [SLOTS];
	logic [63:0] reg_gen;
	logic [4:0]  busy_count;
	logic [4:0]  slots_cfg;

	res_t answer_queue [$];	// predicted results, oldest first
	res_t result_beat;
	int   fail_count;
	int   requests_sent;
	int   answers_seen;
	int   cfg_writes;
	int   status_seen [4];
	bit   gaps_on = 1'b1;	// random idling on both sides

	task automatic registry_reset();
		for (int i = 0; i < SLOTS; i++) begin
			slot_busy[i] = 1'b0;
			slot_tag[i]  = '0;
		end
		reg_gen    = '0;
		busy_count = '0;
		slots_cfg  = 5'd16;
	endtask

	// register values above the table size act as the full table
	function automatic int used_slots();
		return (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
	endfunction

	// release or cleanup: the slot's tag takes the bumped generation, so any
	// handle that was out for it goes stale
	function automatic void retire_slot(input int idx);
		reg_gen        = reg_gen + 64'd1;
		slot_busy[idx] = 1'b0;
		slot_tag[idx]  = reg_gen;
		if (busy_count != 0)
			busy_count = busy_count - 5'd1;
	endfunction

	function automatic res_t registry_predict(input req_t r);
		res_t o;
		int   n;
		o        = '0;
		o.status = ST_ERROR;
		n        = used_slots();
		// zero slots in use or an unknown kind: error, nothing changes
		if (n != 0 && r.req_type <= REQ_LIVE) begin
			case (r.req_type)
			REQ_ALLOC: begin
				if (r.owner_pid != 0 && r.owner_start_time != 0 &&
				    r.owner_boot_hash != 0 && r.mode_word != 0) begin
					o.status = ST_FULL;
					for (int i = 0; i < n; i++) begin
						if (!slot_busy[i]) begin
							reg_gen      = reg_gen + 64'd1;
							slot_busy[i] = 1'b1;
							slot_tag[i]  = reg_gen;
							busy_count   = busy_count + 5'd1;
							o.status     = ST_OK;
							o.grant_idx  = 4'(i);
							o.grant_gen  = reg_gen;
							break;
						end
					end
				end
			end
			REQ_RELEASE, REQ_BEAT: begin
				// zero handle or stamp is an error before the index is looked at
				if (r.handle_gen == 0 || (r.req_type == REQ_BEAT && r.heartbeat_value == 0))
					o.status = ST_ERROR;
				else if (int'(r.handle_idx) >= n || !slot_busy[r.handle_idx] ||
				         slot_tag[r.handle_idx] != r.handle_gen)
					o.status = ST_NOT_FOUND;
				else begin
					if (r.req_type == REQ_RELEASE)
						retire_slot(int'(r.handle_idx));
					o.status = ST_OK;
				end
			end
			REQ_CLEAN: begin
				for (int i = 0; i < n; i++) begin
					if (slot_busy[i] && !r.alive_mask[i]) begin
						retire_slot(i);
						o.count_out = o.count_out + 5'd1;
					end
				end
				o.status = ST_OK;
			end
			default: begin
				for (int i = 0; i < n; i++) begin
					if (slot_busy[i] && r.alive_mask[i])
						o.count_out = o.count_out + 5'd1;
				end
				o.status = ST_OK;
			end
			endcase
		end
		// slots above a lowered slots_in_use still count as active
		o.active_count_out        = busy_count;
		o.registry_generation_out = reg_gen;
		return o;
	endfunction

	// All fields random; identity, handle and stamp kept nonzero so that the
	// zero cases only show up where a test asks for them.
	function automatic req_t random_req(input req_kind_t kind);
		req_t r;
		r.req_type         = kind;
		r.owner_pid        = 31'($urandom);
		r.owner_start_time = {$urandom, $urandom};
		r.owner_boot_hash  = {$urandom, $urandom};
		r.mode_word        = $urandom;
		r.shm_epoch        = {$urandom, $urandom};
		r.handle_idx       = 4'($urandom);
		r.handle_gen       = {$urandom, $urandom};
		r.heartbeat_value  = {$urandom, $urandom};
		r.alive_mask       = 16'($urandom);
		if (r.owner_pid == 0)        r.owner_pid        = 31'd1;
		if (r.owner_start_time == 0) r.owner_start_time = 64'd1;
		if (r.owner_boot_hash == 0)  r.owner_boot_hash  = 64'd1;
		if (r.mode_word == 0)        r.mode_word        = 32'd1;
		if (r.handle_gen == 0)       r.handle_gen       = 64'd1;
		if (r.heartbeat_value == 0)  r.heartbeat_value  = 64'd1;
		return r;
	endfunction

	// release or heartbeat carrying the handle currently held by a slot
	function automatic req_t handle_req(input req_kind_t kind, input int idx);
		req_t r;
		r            = random_req(kind);
		r.handle_idx = 4'(idx);
		r.handle_gen = slot_tag[idx];
		return r;
	endfunction

	function automatic req_t zero_field(input req_t r, input int which);
		req_t z;
		z = r;
		case (which)
		0:       z.owner_pid        = '0;
		1:       z.owner_start_time = '0;
		2:       z.owner_boot_hash  = '0;
		3:       z.mode_word        = '0;
		4:       z.handle_gen       = '0;
		default: z.heartbeat_value  = '0;
		endcase
		return z;
	endfunction

	// One request beat. tvalid is left high after the handshake; the next call
	// either reuses it for the following beat or drops it for an idle gap.
	task automatic send_request(input req_t r);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.req_type;
		s_tdata  <= {5'd0, r.alive_mask, r.heartbeat_value, r.handle_gen, r.handle_idx,
		             r.shm_epoch, r.mode_word, r.owner_boot_hash, r.owner_start_time,
		             r.owner_pid};
		do @(posedge clk); while (!s_tready);
		answer_queue.push_back(registry_predict(r));
		requests_sent++;
	endtask

	// sender holds off until every outstanding result beat has been checked
	task automatic drain_answers();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (answer_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_slots_in_use(input logic [4:0] value);
		drain_answers();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		slots_cfg = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic compare_answer(input res_t want, input res_t got);
		answers_seen++;
		status_seen[want.status]++;
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.grant_idx !== want.grant_idx) begin
			$error("grant_idx: expected %0d, got %0d", want.grant_idx, got.grant_idx);
			fail_count++;
		end
		if (got.grant_gen !== want.grant_gen) begin
			$error("grant_gen: expected %h, got %h", want.grant_gen, got.grant_gen);
			fail_count++;
		end
		if (got.count_out !== want.count_out) begin
			$error("count_out: expected %0d, got %0d", want.count_out, got.count_out);
			fail_count++;
		end
		if (got.active_count_out !== want.active_count_out) begin
			$error("active_count_out: expected %0d, got %0d", want.active_count_out,
			       got.active_count_out);
			fail_count++;
		end
		if (got.registry_generation_out !== want.registry_generation_out) begin
			$error("registry_generation_out: expected %h, got %h",
			       want.registry_generation_out, got.registry_generation_out);
			fail_count++;
		end
	endtask

	// Result side: ready drops at random, and every accepted beat is compared
	// with the oldest prediction.
	always @(negedge clk) begin
		m_tready <= !(gaps_on && $urandom_range(99) < 13);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			result_beat.status                  = m_tuser;
			result_beat.grant_idx               = m_tdata[3:0];
			result_beat.grant_gen               = m_tdata[67:4];
			result_beat.count_out               = m_tdata[72:68];
			result_beat.active_count_out        = m_tdata[77:73];
			result_beat.registry_generation_out = m_tdata[141:78];
			if (answer_queue.size() == 0) begin
				$error("result beat with no request outstanding");
				fail_count++;
			end else begin
				compare_answer(answer_queue.pop_front(), result_beat);
			end
		end
	end

	// Watchdog: any beat on any channel restarts the count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat for %0d cycles", QUIET_MAX);
		$display("** generation_tagged_slot_registry: FAILED **");
		$finish;
	end

	// Fresh registry: nothing to count, nothing to clean.
	task automatic test_empty_registry();
		req_t r;
		r            = random_req(REQ_LIVE);
		r.alive_mask = '1;
		send_request(r);
		r            = random_req(REQ_CLEAN);
		r.alive_mask = '0;
		send_request(r);
	endtask

	// Each zero identity field rejects the allocate; then all-ones and
	// all-minimum owners take slots 0 and 1.
	task automatic test_owner_identity();
		req_t r;
		for (int f = 0; f < 4; f++)
			send_request(zero_field(random_req(REQ_ALLOC), f));
		r                  = random_req(REQ_ALLOC);
		r.owner_pid        = '1;
		r.owner_start_time = '1;
		r.owner_boot_hash  = '1;
		r.mode_word        = '1;
		r.shm_epoch        = '1;
		send_request(r);
		r                  = random_req(REQ_ALLOC);
		r.owner_pid        = 31'd1;
		r.owner_start_time = 64'd1;
		r.owner_boot_hash  = 64'd1;
		r.mode_word        = 32'd1;
		r.shm_epoch        = '0;
		send_request(r);
	endtask

	// Handle checks on slot 0: zero stamp and zero handle are errors, a free
	// slot and a wrong generation are not found, a stale handle after release
	// is not found; a heartbeat with an all-ones stamp is accepted.
	task automatic test_handle_checks();
		req_t r;
		send_request(zero_field(handle_req(REQ_BEAT, 0), 5));
		send_request(zero_field(handle_req(REQ_RELEASE, 0), 4));
		r            = handle_req(REQ_BEAT, 0);
		r.handle_idx = 4'd15;
		send_request(r);
		r            = handle_req(REQ_BEAT, 0);
		r.handle_gen = slot_tag[0] + 64'd1;
		send_request(r);
		r                 = handle_req(REQ_BEAT, 0);
		r.heartbeat_value = '1;
		send_request(r);
		r = handle_req(REQ_RELEASE, 0);
		send_request(r);
		send_request(r);
	endtask

	task automatic test_unknown_kinds();
		for (int k = REQ_LIVE + 1; k < 8; k++)
			send_request(random_req(3'(k)));
	endtask

	// slots_in_use extremes: small table fills up, an index past the table is
	// not found, zero slots rejects everything, an oversized value acts as 16.
	task automatic test_slot_limits();
		req_t r;
		set_slots_in_use(5'd2);
		repeat (3)
			send_request(random_req(REQ_ALLOC));
		set_slots_in_use(5'd1);
		send_request(handle_req(REQ_BEAT, 1));
		r            = random_req(REQ_LIVE);
		r.alive_mask = '1;
		send_request(r);
		set_slots_in_use(5'd0);
		send_request(random_req(REQ_ALLOC));
		send_request(r);
		set_slots_in_use(5'd31);
		send_request(random_req(REQ_ALLOC));
		send_request(r);
		r            = random_req(REQ_CLEAN);
		r.alive_mask = '0;
		send_request(r);
	endtask

	// Mostly well-formed traffic: allocates, releases and heartbeats with
	// handles the table really holds, cleanups with mostly-alive masks; the
	// rest is live counts, stale handles, zero fields and unknown kinds.
	task automatic random_request();
		req_t r;
		int   roll;
		int   held [$];
		roll = $urandom_range(99);
		for (int i = 0; i < SLOTS; i++)
			if (slot_busy[i])
				held.push_back(i);
		if (roll < 30) begin
			r = random_req(REQ_ALLOC);
		end else if (roll < 75) begin
			r = random_req((roll < 55) ? REQ_RELEASE : REQ_BEAT);
			if (held.size() != 0 && $urandom_range(9) < 8) begin
				r = handle_req(r.req_type, held[$urandom_range(held.size() - 1)]);
			end else if ($urandom_range(1) == 1) begin
				// recent generation: likely a handle some slot used to hold
				r.handle_gen = reg_gen - 64'($urandom_range(3));
				if (r.handle_gen == 0)
					r.handle_gen = 64'd1;
			end
		end else if (roll < 85) begin
			r = random_req(REQ_CLEAN);
			if ($urandom_range(3) != 0)
				r.alive_mask = r.alive_mask | 16'($urandom);
		end else if (roll < 95) begin
			r = random_req(REQ_LIVE);
		end else begin
			r = zero_field(random_req(3'($urandom)), $urandom_range(5));
		end
		send_request(r);
	endtask

	task automatic test_random_traffic();
		logic [4:0] plan [7] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd9, 5'd16};
		int         len;
		for (int p = 0; p < 7; p++) begin
			set_slots_in_use(plan[p]);
			gaps_on = (p != 6);	// last phase runs back to back on both sides
			len     = (plan[p] == 0) ? 10 : 147;
			for (int k = 0; k < len; k++) begin
				if (k % 50 == 49)
					drain_answers();
				random_request();
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		registry_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_registry();
		test_owner_identity();
		test_handle_checks();
		test_unknown_kinds();
		test_slot_limits();
		test_random_traffic();

		drain_answers();
		repeat (25) @(posedge clk);

		$display("slot registry: %0d requests, %0d results checked, %0d slots_in_use writes",
		         requests_sent, answers_seen, cfg_writes);
		$display("answers: ok %0d, error %0d, full %0d, not found %0d",
		         status_seen[ST_OK], status_seen[ST_ERROR], status_seen[ST_FULL],
		         status_seen[ST_NOT_FOUND]);
		if (fail_count == 0 && answer_queue.size() == 0) begin
			$display("** generation_tagged_slot_registry: PASSED **");
		end else begin
			$display("** generation_tagged_slot_registry: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sgr_pkg.sv
hdl/sgr_rec_mem.sv
hdl/sgr_seq.sv
hdl/generation_tagged_slot_registry.sv
hdl/sgr_chk.sv
dv/generation_tagged_slot_registry_tb.sv
